### src/aabb_pkg.sv
// Package: types and constants shared by the bounding box transform files.
`default_nettype none
package aabb_pkg;

    // Coordinate and coefficient word width (Q16.16)
    localparam int COORD_W     = 32;
    // Saturation range of a transformed coordinate, in bits
    localparam int COORD_WIDTH = 32;
    // Exact Q32.32 accumulator: three products, translation and rounding half
    localparam int ACC_W       = 66;
    // Rounded Q34.16 sum before saturation
    localparam int SUM_W       = ACC_W - 16;
    localparam int NUM_AXES    = 3;
    localparam int NUM_REGS    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z_SECOND = 3'd5;

    // Reset matrix is the identity
    localparam logic [CFG_DATA_W-1:0] RST_FIRST_X  = 64'h0001_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_FIRST_Y  = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] RST_FIRST_Z  = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_SECOND_X = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_SECOND_Y = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_SECOND_Z = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic               box_empty;
        logic [COORD_W-1:0] low_x;
        logic [COORD_W-1:0] low_y;
        logic [COORD_W-1:0] low_z;
        logic [COORD_W-1:0] high_x;
        logic [COORD_W-1:0] high_y;
        logic [COORD_W-1:0] high_z;
    } box_t;

    typedef struct packed {
        logic               out_empty;
        logic [COORD_W-1:0] out_low_x;
        logic [COORD_W-1:0] out_low_y;
        logic [COORD_W-1:0] out_low_z;
        logic [COORD_W-1:0] out_high_x;
        logic [COORD_W-1:0] out_high_y;
        logic [COORD_W-1:0] out_high_z;
    } box_out_t;

    // Word travelling down the chain of cells
    typedef struct packed {
        logic                               valid;
        box_t                               box;
        logic [NUM_AXES-1:0][ACC_W-1:0]     acc_min;
        logic [NUM_AXES-1:0][ACC_W-1:0]     acc_max;
    } chain_t;

endpackage
`default_nettype wire

### src/aabb_box_in_if.sv
// Interface: input box channel.
`default_nettype none
interface aabb_box_in_if;
    import aabb_pkg::*;
    logic valid;
    logic ready;
    box_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/aabb_box_out_if.sv
// Interface: result box channel.
`default_nettype none
interface aabb_box_out_if;
    import aabb_pkg::*;
    logic     valid;
    logic     ready;
    box_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/aabb_cell.sv
// Cell: one input axis, adds its min and max product terms to all three rows.
`default_nettype none
module aabb_cell (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       advance,
    input  wire aabb_pkg::chain_t                           bus_in,
    input  wire logic [aabb_pkg::COORD_W-1:0]               lo,
    input  wire logic [aabb_pkg::COORD_W-1:0]               hi,
    input  wire logic [aabb_pkg::NUM_AXES-1:0][aabb_pkg::COORD_W-1:0] coef,
    output aabb_pkg::chain_t                                bus_out
);
    import aabb_pkg::*;

    localparam int PROD_W = 2 * COORD_W;

    logic                    s1_valid_reg;
    chain_t                  s1_bus_reg;
    logic signed [PROD_W-1:0] p_lo_reg [NUM_AXES];
    logic signed [PROD_W-1:0] p_hi_reg [NUM_AXES];
    logic                    s2_valid_reg;
    chain_t                  s2_bus_reg;
    chain_t                  s2_bus_next;

    // Stage 1: products of each row coefficient with both bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= bus_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_bus_reg <= bus_in;
            for (int r = 0; r < NUM_AXES; r++)
            begin
                p_lo_reg[r] <= $signed(coef[r]) * $signed(lo);
                p_hi_reg[r] <= $signed(coef[r]) * $signed(hi);
            end
        end
    end

    // Stage 2: smaller term into the min sum, larger into the max sum
    always_comb
    begin
        logic signed [ACC_W-1:0] e_lo;
        logic signed [ACC_W-1:0] e_hi;
        s2_bus_next = s1_bus_reg;
        s2_bus_next.valid = s1_valid_reg;
        for (int r = 0; r < NUM_AXES; r++)
        begin
            e_lo = ACC_W'(p_lo_reg[r]);
            e_hi = ACC_W'(p_hi_reg[r]);
            if (e_lo < e_hi)
            begin
                s2_bus_next.acc_min[r] = s1_bus_reg.acc_min[r] + e_lo;
                s2_bus_next.acc_max[r] = s1_bus_reg.acc_max[r] + e_hi;
            end
            else
            begin
                s2_bus_next.acc_min[r] = s1_bus_reg.acc_min[r] + e_hi;
                s2_bus_next.acc_max[r] = s1_bus_reg.acc_max[r] + e_lo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_bus_reg <= s2_bus_next;
        end
    end

    always_comb
    begin
        bus_out = s2_bus_reg;
        bus_out.valid = s2_valid_reg;
    end

endmodule
`default_nettype wire

### src/aabb_affine_transform_core.sv
// Top level: affine transform of an axis-aligned box through a chain of axis cells.
// Usage:
//   in_box carries one box word (empty flag, min and max corner, Q16.16) under
//   valid/ready. out_box carries the bounding box of its image under the
//   configured 3x4 affine matrix, written through cfg_we, cfg_index and cfg_data,
//   one 64-bit register per write. Write only while idle; the block does not enforce it.
// Pipeline and throughput:
//   An accepted word passes through three axis cells of two stages each
//   (multiply, then min/max accumulate), the last of them feeding the
//   round-and-saturate output register. One word is taken every cycle while
//   out_box does not stall; the three-cell pipeline with its 18 multipliers sustains that rate.
// Reset:
//   Clears all pipeline valid flags and loads the identity matrix.
// Stall:
//   When out_box.ready is low with a word waiting, the whole chain holds and
//   in_box.ready drops in the same cycle; no word is lost or repeated.
`default_nettype none
module aabb_affine_transform_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [aabb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [aabb_pkg::CFG_DATA_W-1:0]  cfg_data,
    aabb_box_in_if.sink                           in_box,
    aabb_box_out_if.source                        out_box
);
    import aabb_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) <<< (COORD_WIDTH - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    logic [CFG_DATA_W-1:0] cfg_reg [NUM_REGS];
    logic                  advance;
    chain_t                chain [NUM_AXES+1];
    logic [NUM_AXES-1:0][COORD_W-1:0] lo_sel;
    logic [NUM_AXES-1:0][COORD_W-1:0] hi_sel;
    logic [NUM_AXES-1:0][NUM_AXES-1:0][COORD_W-1:0] coef_sel;
    logic                  out_valid_reg;
    box_out_t              out_reg;
    box_out_t              out_next;

    // Matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ROW_X_FIRST]  <= RST_FIRST_X;
            cfg_reg[REG_ROW_X_SECOND] <= RST_SECOND_X;
            cfg_reg[REG_ROW_Y_FIRST]  <= RST_FIRST_Y;
            cfg_reg[REG_ROW_Y_SECOND] <= RST_SECOND_Y;
            cfg_reg[REG_ROW_Z_FIRST]  <= RST_FIRST_Z;
            cfg_reg[REG_ROW_Z_SECOND] <= RST_SECOND_Z;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_X_FIRST:  cfg_reg[REG_ROW_X_FIRST]  <= cfg_data;
                REG_ROW_X_SECOND: cfg_reg[REG_ROW_X_SECOND] <= cfg_data;
                REG_ROW_Y_FIRST:  cfg_reg[REG_ROW_Y_FIRST]  <= cfg_data;
                REG_ROW_Y_SECOND: cfg_reg[REG_ROW_Y_SECOND] <= cfg_data;
                REG_ROW_Z_FIRST:  cfg_reg[REG_ROW_Z_FIRST]  <= cfg_data;
                REG_ROW_Z_SECOND: cfg_reg[REG_ROW_Z_SECOND] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole chain moves when the output register is free or being drained
    assign advance      = !out_valid_reg || out_box.ready;
    assign in_box.ready = advance;

    // Chain head: sums start at translation in Q32.32 plus the rounding half
    always_comb
    begin
        chain[0].valid = in_box.valid;
        chain[0].box   = in_box.data;
        for (int r = 0; r < NUM_AXES; r++)
        begin
            chain[0].acc_min[r] = {{(ACC_W-COORD_W-16){cfg_reg[2*r+1][COORD_W-1]}},
                                   cfg_reg[2*r+1][COORD_W-1:0], 16'h8000};
            chain[0].acc_max[r] = chain[0].acc_min[r];
        end
    end

    // Per-cell bound and coefficient selection
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            lo_sel[k] = '0;
            hi_sel[k] = '0;
        end
        lo_sel[0] = chain[0].box.low_x;
        hi_sel[0] = chain[0].box.high_x;
        lo_sel[1] = chain[1].box.low_y;
        hi_sel[1] = chain[1].box.high_y;
        lo_sel[2] = chain[2].box.low_z;
        hi_sel[2] = chain[2].box.high_z;
        for (int r = 0; r < NUM_AXES; r++)
        begin
            coef_sel[0][r] = cfg_reg[2*r][CFG_DATA_W-1:COORD_W];
            coef_sel[1][r] = cfg_reg[2*r][COORD_W-1:0];
            coef_sel[2][r] = cfg_reg[2*r+1][CFG_DATA_W-1:COORD_W];
        end
    end

    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_cell
        aabb_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .bus_in  (chain[k]),
            .lo      (lo_sel[k]),
            .hi      (hi_sel[k]),
            .coef    (coef_sel[k]),
            .bus_out (chain[k+1])
        );
    end

    // Round to Q16.16 and saturate
    function automatic logic [COORD_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
        logic signed [SUM_W-1:0] v;
        v = $signed(acc[ACC_W-1:16]);
        if (v > SAT_MAX)
        begin
            v = SAT_MAX;
        end
        else if (v < SAT_MIN)
        begin
            v = SAT_MIN;
        end
        return v[COORD_W-1:0];
    endfunction

    always_comb
    begin
        if (chain[NUM_AXES].box.box_empty)
        begin
            out_next = '0;
            out_next.out_empty = 1'b1;
        end
        else
        begin
            out_next.out_empty  = 1'b0;
            out_next.out_low_x  = round_sat(chain[NUM_AXES].acc_min[0]);
            out_next.out_low_y  = round_sat(chain[NUM_AXES].acc_min[1]);
            out_next.out_low_z  = round_sat(chain[NUM_AXES].acc_min[2]);
            out_next.out_high_x = round_sat(chain[NUM_AXES].acc_max[0]);
            out_next.out_high_y = round_sat(chain[NUM_AXES].acc_max[1]);
            out_next.out_high_z = round_sat(chain[NUM_AXES].acc_max[2]);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain[NUM_AXES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_box.valid = out_valid_reg;
    assign out_box.data  = out_reg;

    // Result box never inverted
    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.out_empty) |->
            ($signed(out_reg.out_low_x) <= $signed(out_reg.out_high_x) &&
             $signed(out_reg.out_low_y) <= $signed(out_reg.out_high_y) &&
             $signed(out_reg.out_low_z) <= $signed(out_reg.out_high_z)))
        else $error("result box inverted");

    // Empty result carries zero corners
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.out_empty) |->
            (out_reg.out_low_x == '0 && out_reg.out_high_x == '0 &&
             out_reg.out_low_y == '0 && out_reg.out_high_y == '0 &&
             out_reg.out_low_z == '0 && out_reg.out_high_z == '0))
        else $error("empty result with nonzero corners");

    // A pending result leaves only when taken
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_box.ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result lost");

endmodule
`default_nettype wire

### tb/sv/tb_aabb_affine_transform_core.sv
// Testbench for the affine bounding box transform core: directed and random boxes, self-checked.
`default_nettype none
module tb_aabb_affine_transform_core;
    timeunit 1ns;
    timeprecision 1ps;
    import aabb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 200;
    localparam int HOLD_AT_WORD   = 400;
    localparam int PHASE_WORDS    = 210;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    // Transform model and store of expected result boxes
    class box_scoreboard;
        logic [CFG_DATA_W-1:0] matrix [NUM_REGS];
        box_out_t expected_boxes [$];
        int errors;
        int checked;

        function new();
            matrix[REG_ROW_X_FIRST]  = RST_FIRST_X;
            matrix[REG_ROW_X_SECOND] = RST_SECOND_X;
            matrix[REG_ROW_Y_FIRST]  = RST_FIRST_Y;
            matrix[REG_ROW_Y_SECOND] = RST_SECOND_Y;
            matrix[REG_ROW_Z_FIRST]  = RST_FIRST_Z;
            matrix[REG_ROW_Z_SECOND] = RST_SECOND_Z;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx < NUM_REGS)
                matrix[idx] = value;
        endfunction

        // One row of the matrix applied to one corner, rounded and saturated
        function logic signed [31:0] transform_axis(int row, logic [31:0] x,
                                                    logic [31:0] y, logic [31:0] z);
            logic signed [69:0] ca, cb, cc, tr, px, py, pz, acc;
            ca = $signed(matrix[2*row][63:32]);
            cb = $signed(matrix[2*row][31:0]);
            cc = $signed(matrix[2*row+1][63:32]);
            tr = $signed(matrix[2*row+1][31:0]);
            px = $signed(x);
            py = $signed(y);
            pz = $signed(z);
            acc = ca * px + cb * py + cc * pz + (tr <<< 16) + 70'sh8000;
            acc = acc >>> 16;
            if (acc > 70'sd2147483647)
                acc = 70'sd2147483647;
            if (acc < -70'sd2147483648)
                acc = -70'sd2147483648;
            return acc[31:0];
        endfunction

        // Bounding box of the eight transformed corners
        function void note_input(box_t b);
            box_out_t r;
            logic signed [31:0] lo [3];
            logic signed [31:0] hi [3];
            logic signed [31:0] v;
            logic [31:0] cx, cy, cz;
            r = '0;
            if (b.box_empty) begin
                r.out_empty = 1'b1;
            end else begin
                for (int c = 0; c < 8; c++) begin
                    cx = c[0] ? b.high_x : b.low_x;
                    cy = c[1] ? b.high_y : b.low_y;
                    cz = c[2] ? b.high_z : b.low_z;
                    for (int a = 0; a < 3; a++) begin
                        v = transform_axis(a, cx, cy, cz);
                        if (c == 0 || v < lo[a]) lo[a] = v;
                        if (c == 0 || v > hi[a]) hi[a] = v;
                    end
                end
                r.out_low_x  = lo[0];
                r.out_low_y  = lo[1];
                r.out_low_z  = lo[2];
                r.out_high_x = hi[0];
                r.out_high_y = hi[1];
                r.out_high_z = hi[2];
            end
            expected_boxes.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at result %0d: %s got %h expected %h", checked, what, got, want);
            errors++;
        endtask

        task check_result(box_out_t got);
            box_out_t want;
            if (expected_boxes.size() == 0) begin
                report("unexpected word", 32'(got.out_empty), 32'd0);
                return;
            end
            want = expected_boxes.pop_front();
            if (got.out_empty  !== want.out_empty)
                report("out_empty", 32'(got.out_empty), 32'(want.out_empty));
            if (got.out_low_x  !== want.out_low_x)  report("out_low_x", got.out_low_x, want.out_low_x);
            if (got.out_low_y  !== want.out_low_y)  report("out_low_y", got.out_low_y, want.out_low_y);
            if (got.out_low_z  !== want.out_low_z)  report("out_low_z", got.out_low_z, want.out_low_z);
            if (got.out_high_x !== want.out_high_x)
                report("out_high_x", got.out_high_x, want.out_high_x);
            if (got.out_high_y !== want.out_high_y)
                report("out_high_y", got.out_high_y, want.out_high_y);
            if (got.out_high_z !== want.out_high_z)
                report("out_high_z", got.out_high_z, want.out_high_z);
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    aabb_box_in_if  in_ch();
    aabb_box_out_if out_ch();
    box_scoreboard sb;
    bit stimulus_done;
    int words_out;

    aabb_affine_transform_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_box(in_ch), .out_box(out_ch)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Sender: random gap, then hold the word until accepted
    task send_box(box_t b, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(b);
    endtask

    task write_matrix(logic [CFG_DATA_W-1:0] vals [NUM_REGS], bit with_unused);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
        end
        // out-of-range indexes must be ignored
        if (with_unused) begin
            cfg_index <= REG_UNUSED_A;
            cfg_data  <= {$urandom, $urandom};
            @(posedge clk);
            cfg_index <= REG_UNUSED_B;
            cfg_data  <= {$urandom, $urandom};
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Block idle: nothing pending, pipeline flushed
    task wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.expected_boxes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function box_t rand_box();
        box_t b;
        int mode;
        mode = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 5) == 0 ? 2 : 0);
        b.box_empty = ($urandom_range(0, 15) == 0);
        b.low_x  = rand_coord(mode);
        b.low_y  = rand_coord(mode);
        b.low_z  = rand_coord(mode);
        b.high_x = rand_coord(mode);
        b.high_y = rand_coord(mode);
        b.high_z = rand_coord(mode);
        // mostly well-ordered boxes, some inverted
        if ($urandom_range(0, 3) != 0) begin
            if ($signed(b.low_x) > $signed(b.high_x)) {b.low_x, b.high_x} = {b.high_x, b.low_x};
            if ($signed(b.low_y) > $signed(b.high_y)) {b.low_y, b.high_y} = {b.high_y, b.low_y};
            if ($signed(b.low_z) > $signed(b.high_z)) {b.low_z, b.high_z} = {b.high_z, b.low_z};
        end
        return b;
    endfunction

    function logic [31:0] rand_coef(int kind);
        case (kind)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom;
            default: return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
        endcase
    endfunction

    // Stimulus
    initial
    begin
        box_t b;
        logic [CFG_DATA_W-1:0] vals [NUM_REGS];
        int kind;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        stimulus_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed and random boxes under the reset identity
        b = '0;
        send_box(b, 1'b0);
        b.box_empty = 1'b1;
        b.low_x = 32'hDEAD_BEEF;
        b.high_z = 32'h1234_5678;
        send_box(b, 1'b0);
        b = '0;
        b.low_x = 32'h8000_0000; b.low_y = 32'h8000_0000; b.low_z = 32'h8000_0000;
        b.high_x = 32'h7FFF_FFFF; b.high_y = 32'h7FFF_FFFF; b.high_z = 32'h7FFF_FFFF;
        send_box(b, 1'b1);
        b = '0;
        b.low_x = 32'h7FFF_FFFF; b.high_x = 32'h8000_0000;
        b.low_y = 32'h0001_0000; b.high_y = 32'hFFFF_0000;
        b.low_z = 32'h0000_0001; b.high_z = 32'hFFFF_FFFF;
        send_box(b, 1'b1);
        b = '0;
        b.low_x = 32'hFFFF_FFFF; b.low_y = 32'hFFFF_FFFF; b.low_z = 32'hFFFF_FFFF;
        b.high_x = 32'hFFFF_FFFF; b.high_y = 32'hFFFF_FFFF; b.high_z = 32'hFFFF_FFFF;
        send_box(b, 1'b0);
        for (int i = 0; i < 6; i++)
            send_box(rand_box(), 1'b1);
        wait_idle();

        // Extreme matrices, then rounding ties with half-scale coefficients
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < NUM_REGS; i++)
                vals[i] = {rand_coef(k), rand_coef(k)};
            write_matrix(vals, k == 0);
            b = '0;
            b.low_x = 32'h8000_0000; b.low_y = 32'h8000_0000; b.low_z = 32'h8000_0000;
            b.high_x = 32'h7FFF_FFFF; b.high_y = 32'h7FFF_FFFF; b.high_z = 32'h7FFF_FFFF;
            send_box(b, 1'b0);
            send_box(rand_box(), 1'b1);
            wait_idle();
        end
        for (int i = 0; i < NUM_REGS; i++)
            vals[i] = {32'h0000_8000, 32'hFFFF_8000};
        write_matrix(vals, 1'b0);
        b = '0;
        b.low_x = 32'h0000_0001; b.low_y = 32'hFFFF_FFFF; b.low_z = 32'h0000_0003;
        b.high_x = 32'h0000_0002; b.high_y = 32'h0000_0001; b.high_z = 32'hFFFF_FFFD;
        send_box(b, 1'b0);
        wait_idle();

        // Random phases, each under a fresh matrix
        for (int ph = 0; ph < 8; ph++) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                kind = (ph < 2) ? 3 : ((ph == 7) ? $urandom_range(0, 4) : 4);
                vals[i] = {rand_coef(kind), rand_coef(kind)};
            end
            write_matrix(vals, ph == 3);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_box(rand_box(), (ph % 3) != 2);
            wait_idle();
        end
        stimulus_done = 1'b1;
    end

    // Receiver with random stalls and one long hold-off
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        words_out = 0;
        @(posedge rst_n);
        forever begin
            stall = (words_out == HOLD_AT_WORD) ? LONG_HOLD
                  : (((words_out / 100) % 4 == 1) ? 0 : $urandom_range(0, 3));
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            sb.check_result(out_ch.data);
            words_out++;
        end
    end

    // Watchdog on cycles with no accepted word, and end of run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (!(stimulus_done && sb.expected_boxes.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[aabb_affine_transform_core] ERROR");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (sb.errors == 0 && sb.expected_boxes.size() == 0)
                $display("[aabb_affine_transform_core] OK");
            else
                $display("[aabb_affine_transform_core] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
